FILE: design/sha256_stream_hasher_assert.svh
// Assertion macros shared by the hasher's checking code.
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SHA_AST_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SHA_AST_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/sha_pkg.sv
// Shared types, constants and round functions of the SHA-256 stream hasher.
package sha_pkg;

    localparam int unsigned CMD_FIFO_DEPTH = 4;
    localparam int unsigned TOTAL_W = 61;
    localparam logic [TOTAL_W-1:0] MAX_BYTES = {TOTAL_W{1'b1}};

    // One classified item handed from the front to the core.
    typedef struct packed {
        logic               has_byte;
        logic [7:0]         data_byte;
        logic               eom;
        logic               err;
        logic [TOTAL_W-1:0] total;
    } cmd_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef logic [31:0] word_t;

    function automatic word_t hash_init(input logic [2:0] i);
        word_t r;
        case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic word_t round_k(input logic [5:0] t);
        word_t r;
        case (t)
            6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
            6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
            6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
            6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
            6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

    function automatic word_t rotr(input word_t v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic word_t big_s0(input word_t v);
        return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic word_t big_s1(input word_t v);
        return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic word_t sm_s0(input word_t v);
        return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic word_t sm_s1(input word_t v);
        return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

endpackage

FILE: design/sha_if.sv
// Stream channel interfaces for message bytes and digest words.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, has_byte, data_byte, end_of_message, input ready);
    modport sink (input valid, has_byte, data_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        length_error;

    modport source (output valid, digest_word, word_index, last_word, length_error,
                    input ready);
    modport sink (input valid, digest_word, word_index, last_word, length_error,
                  output ready);
endinterface

FILE: design/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher.
// SHA-256 over a byte stream: at most one message byte per input item, an item with
// end_of_message closes the message and yields eight digest words (word 0
// first) or a single length_error item if the byte count passed 2^61-1.
// Items are accepted at one per cycle while the four-entry command queue has
// room. The core takes one queued byte per cycle while idle and runs its
// single round unit over each full block, then an add step, taking no bytes
// meanwhile. Closing an error-free message costs one or two padded blocks,
// then eight output items with the digest words.
module sha256_stream_hasher #(
    parameter int unsigned FIFO_DEPTH = sha_pkg::CMD_FIFO_DEPTH
) (
    input logic       clk,
    input logic       rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    import sha_pkg::*;

`include "sha256_stream_hasher_assert.svh"

    cmd_t    push_cmd, head;
    q_stat_t qs;
    logic    push, pop;

    sha_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .qs    (qs),
        .push  (push),
        .cmd   (push_cmd)
    );

    sha_cmd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (qs)
    );

    sha_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qs     (qs),
        .pop    (pop),
        .out_ch (out_ch)
    );

    // Checks
    `SHA_AST_NOW(a_no_push_full, push, !qs.full, "command pushed into full queue")
    `SHA_AST_NOW(a_no_pop_empty, pop, !qs.empty, "command popped from empty queue")
    `SHA_AST_NOW(a_err_form, out_ch.valid && out_ch.length_error,
                 out_ch.last_word && (out_ch.word_index == 3'd0) && (out_ch.digest_word == '0),
                 "malformed error item")
    `SHA_AST_NOW(a_last_idx, out_ch.valid && out_ch.last_word && !out_ch.length_error,
                 out_ch.word_index == 3'd7, "last digest word not at index 7")
endmodule

FILE: design/sha_cmd_fifo.sv
// Short command queue between the front and the compression core.
module sha_cmd_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sha_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output sha_pkg::cmd_t    head,
    output sha_pkg::q_stat_t stat
);
    import sha_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLC = CW'(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push, do_pop;

    assign stat.full  = (cnt_reg == FULLC);
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_reg];

    // Storage
    always_ff @(posedge clk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == LAST) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == LAST) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule

FILE: design/sha_front.sv
// Front end: accepts items, tracks message length and limit, queues commands.
module sha_front (
    input  logic             clk,
    input  logic             rst_n,
    sha_in_if.sink           in_ch,
    input  sha_pkg::q_stat_t qs,
    output logic             push,
    output sha_pkg::cmd_t    cmd
);
    import sha_pkg::*;

    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               ovf_reg, ovf_next;
    logic               take, acc;

    assign in_ch.ready = !qs.full;
    assign acc         = in_ch.valid && in_ch.ready;

    // Classify: take the byte unless the length limit is reached
    always_comb begin
        take       = in_ch.has_byte && !ovf_reg && (total_reg != MAX_BYTES);
        ovf_next   = ovf_reg || (in_ch.has_byte && !ovf_reg && (total_reg == MAX_BYTES));
        total_next = take ? total_reg + 1'b1 : total_reg;
    end

    assign push          = acc && (take || in_ch.end_of_message);
    assign cmd.has_byte  = take;
    assign cmd.data_byte = in_ch.data_byte;
    assign cmd.eom       = in_ch.end_of_message;
    assign cmd.err       = ovf_next;
    assign cmd.total     = total_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            total_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (acc) begin
            if (in_ch.end_of_message) begin
                total_reg <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                total_reg <= total_next;
                ovf_reg   <= ovf_next;
            end
        end
    end
endmodule

FILE: design/sha_core.sv
// Back end: byte packing, padding, 64-round compression, digest and error output.
module sha_core (
    input  logic             clk,
    input  logic             rst_n,
    input  sha_pkg::cmd_t    head,
    input  sha_pkg::q_stat_t qs,
    output logic             pop,
    sha_out_if.source        out_ch
);
    import sha_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RND  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_LEN  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_ERR  = 3'd5;

    localparam logic [1:0] PH_NORM = 2'd0;
    localparam logic [1:0] PH_PAD1 = 2'd1;
    localparam logic [1:0] PH_PAD2 = 2'd2;

    logic [2:0]         state_reg;
    logic [1:0]         phase_reg;
    logic [5:0]         t_reg;
    logic [5:0]         fill_reg;
    logic               bdone_reg;
    logic [2:0]         idx_reg;
    logic [TOTAL_W-1:0] len_reg;
    word_t              hash_reg [8];
    word_t              v_reg [8];
    word_t              buf_reg [16];
    logic               ovalid_reg;
    word_t              odig_reg;
    logic [2:0]         oidx_reg;
    logic               olast_reg, oerr_reg;

    word_t w_t, t1, t2, ins, padw;
    logic  out_free;
    logic  emit_now;
    logic [3:0] wi;
    logic [1:0] ki;

    assign out_free            = !ovalid_reg || out_ch.ready;
    assign emit_now            = ((state_reg == S_EMIT) || (state_reg == S_ERR)) && out_free;
    assign out_ch.valid        = ovalid_reg;
    assign out_ch.digest_word  = odig_reg;
    assign out_ch.word_index   = oidx_reg;
    assign out_ch.last_word    = olast_reg;
    assign out_ch.length_error = oerr_reg;

    assign wi = fill_reg[5:2];
    assign ki = fill_reg[1:0];

    // Round datapath and byte insertion
    always_comb begin
        if (t_reg < 6'd16) begin
            w_t = buf_reg[0];
        end else begin
            w_t = sm_s1(buf_reg[14]) + buf_reg[9] + sm_s0(buf_reg[1]) + buf_reg[0];
        end
        t1 = v_reg[7] + big_s1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + round_k(t_reg) + w_t;
        t2 = big_s0(v_reg[0]) +
             ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        if (ki == 2'd0) begin
            ins  = {head.data_byte, 24'd0};
            padw = 32'h8000_0000;
        end else begin
            ins  = buf_reg[wi] | ({24'd0, head.data_byte} << (5'd8 * (5'd3 - {3'd0, ki})));
            padw = (buf_reg[wi] & ~(32'hFFFF_FFFF >> (6'd8 * {4'd0, ki})))
                   | (32'h80 << (5'd8 * (5'd3 - {3'd0, ki})));
        end
    end

    assign pop = (state_reg == S_IDLE) && !qs.empty &&
                 !(head.has_byte && !bdone_reg && head.eom);

    // Output valid: set on a new result item, cleared once it is taken
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ovalid_reg <= 1'b0;
        end else if (emit_now) begin
            ovalid_reg <= 1'b1;
        end else if (out_ch.ready) begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_NORM;
            fill_reg   <= '0;
            bdone_reg  <= 1'b0;
            t_reg      <= '0;
            idx_reg    <= '0;
            for (int i = 0; i < 8; i++) begin
                hash_reg[i] <= hash_init(3'(i));
            end
        end else begin
            unique case (state_reg)
                // Dispatch one queued command
                S_IDLE: begin
                    if (!qs.empty) begin
                        if (head.has_byte && !bdone_reg) begin
                            buf_reg[wi] <= ins;
                            fill_reg    <= fill_reg + 1'b1;
                            bdone_reg   <= head.eom;
                            if (fill_reg == 6'd63) begin
                                for (int i = 0; i < 8; i++) begin
                                    v_reg[i] <= hash_reg[i];
                                end
                                t_reg     <= '0;
                                phase_reg <= PH_NORM;
                                state_reg <= S_RND;
                            end
                        end else begin
                            bdone_reg <= 1'b0;
                            if (head.err) begin
                                state_reg <= S_ERR;
                            end else begin
                                // Padding: marker byte, zeros, then the bit length
                                for (int i = 0; i < 16; i++) begin
                                    if ((fill_reg < 6'd56) && (i == 14)) begin
                                        buf_reg[i] <= head.total[TOTAL_W-1:29];
                                    end else if ((fill_reg < 6'd56) && (i == 15)) begin
                                        buf_reg[i] <= {head.total[28:0], 3'b000};
                                    end else if (4'(i) == wi) begin
                                        buf_reg[i] <= padw;
                                    end else if (4'(i) > wi) begin
                                        buf_reg[i] <= '0;
                                    end
                                end
                                len_reg <= head.total;
                                if (fill_reg >= 6'd56) begin
                                    phase_reg <= PH_PAD1;
                                end else begin
                                    phase_reg <= PH_PAD2;
                                end
                                for (int i = 0; i < 8; i++) begin
                                    v_reg[i] <= hash_reg[i];
                                end
                                t_reg     <= '0;
                                state_reg <= S_RND;
                            end
                        end
                    end
                end
                // One compression round per cycle; the buffer doubles as schedule window
                S_RND: begin
                    for (int i = 0; i < 15; i++) begin
                        buf_reg[i] <= buf_reg[i+1];
                    end
                    buf_reg[15] <= w_t;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    t_reg    <= t_reg + 1'b1;
                    if (t_reg == 6'd63) begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    end
                    if (phase_reg == PH_PAD1) begin
                        state_reg <= S_LEN;
                    end else if (phase_reg == PH_PAD2) begin
                        idx_reg   <= '0;
                        state_reg <= S_EMIT;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                // Extra length-only block
                S_LEN: begin
                    for (int i = 0; i < 14; i++) begin
                        buf_reg[i] <= '0;
                    end
                    buf_reg[14] <= len_reg[TOTAL_W-1:29];
                    buf_reg[15] <= {len_reg[28:0], 3'b000};
                    for (int i = 0; i < 8; i++) begin
                        v_reg[i] <= hash_reg[i];
                    end
                    t_reg     <= '0;
                    phase_reg <= PH_PAD2;
                    state_reg <= S_RND;
                end
                S_EMIT: begin
                    if (out_free) begin
                        odig_reg   <= hash_reg[idx_reg];
                        oidx_reg   <= idx_reg;
                        olast_reg  <= (idx_reg == 3'd7);
                        oerr_reg   <= 1'b0;
                        idx_reg    <= idx_reg + 1'b1;
                        if (idx_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++) begin
                                hash_reg[i] <= hash_init(3'(i));
                            end
                            fill_reg  <= '0;
                            phase_reg <= PH_NORM;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        odig_reg   <= '0;
                        oidx_reg   <= '0;
                        olast_reg  <= 1'b1;
                        oerr_reg   <= 1'b1;
                        for (int i = 0; i < 8; i++) begin
                            hash_reg[i] <= hash_init(3'(i));
                        end
                        fill_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: test/tb_sha256_stream_hasher.sv
// Self-checking testbench for the SHA-256 stream hasher: directed and random messages.
`timescale 1ns / 1ps

module tb_sha256_stream_hasher;
    import sha_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
        logic        err;
    } digest_item_t;

    logic clk;
    logic rst_n;

    sha_in_if  in_ch();
    sha_out_if out_ch();

    sha256_stream_hasher uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Predicted digest words, oldest first
    digest_item_t digest_queue[$];
    int           error_count = 0;
    int           items_sent = 0;
    int           hold_seq = 0;

    // Predictor copy of the hashing state
    logic [31:0] hash_state[8];
    logic [7:0]  block_bytes[64];
    int          block_fill;
    longint      message_len;

    localparam logic [31:0] H_INIT[8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_ROUND[64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror32(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // One 64-round compression of block_bytes into hash_state
    function automatic void compress_block_bytes();
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
        begin
            w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                    block_bytes[4*t+3]};
        end
        for (int t = 16; t < 64; t++)
        begin
            s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int t = 0; t < 64; t++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) +
                 ((e & f) ^ (~e & g)) + K_ROUND[t] + w[t];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) +
                 ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++)
            hash_state[i] = H_INIT[i];
        block_fill = 0;
        message_len = 0;
    endfunction

    // Advance the predictor by one accepted item; push digest words on end
    function automatic void predict_digest(logic has_b, logic [7:0] data_b, logic eom);
        logic [63:0]  bit_len;
        digest_item_t d;
        if (has_b)
        begin
            block_bytes[block_fill] = data_b;
            block_fill++;
            message_len++;
            if (block_fill == 64)
            begin
                compress_block_bytes();
                block_fill = 0;
            end
        end
        if (!eom)
            return;
        // padding: 0x80, zeros, 64-bit bit length; a second block if no room
        block_bytes[block_fill] = 8'h80;
        for (int i = block_fill + 1; i < 64; i++)
            block_bytes[i] = 8'h00;
        if (block_fill >= 56)
        begin
            compress_block_bytes();
            for (int i = 0; i < 64; i++)
                block_bytes[i] = 8'h00;
        end
        bit_len = message_len << 3;
        for (int i = 0; i < 8; i++)
            block_bytes[56 + i] = bit_len[63 - 8*i -: 8];
        compress_block_bytes();
        for (int i = 0; i < 8; i++)
        begin
            d.word = hash_state[i];
            d.index = i[2:0];
            d.last = (i == 7);
            d.err = 1'b0;
            digest_queue.push_back(d);
        end
        restart_hash();
    endfunction

    // Clock: 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Mostly short gaps, a few long ones
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // Drive one item and wait for acceptance; valid stays high afterwards
    task automatic send_item(logic has_b, logic [7:0] data_b, logic eom, bit allow_gap);
        int gap;
        gap = allow_gap ? random_gap() : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.has_byte <= has_b;
        in_ch.data_byte <= data_b;
        in_ch.end_of_message <= eom;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_digest(has_b, data_b, eom);
        items_sent++;
    endtask

    task automatic send_message(int len, bit bare_end, bit allow_gap);
        for (int i = 0; i < len; i++)
        begin
            // occasional filler item that carries nothing
            if ($urandom_range(0, 15) == 0)
                send_item(1'b0, 8'($urandom), 1'b0, allow_gap);
            send_item(1'b1, 8'($urandom), (i == len - 1) && !bare_end, allow_gap);
        end
        if (bare_end || len == 0)
            send_item(1'b0, 8'($urandom), 1'b1, allow_gap);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (digest_queue.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int seen_seq;
        int hold_left;
        seen_seq = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != seen_seq)
            begin
                seen_seq = hold_seq;
                hold_left = 1500;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= (random_gap() == 0);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        digest_item_t d;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (digest_queue.size() == 0)
                report_mismatch("digest item with nothing expected");
            else
            begin
                d = digest_queue.pop_front();
                if (out_ch.digest_word !== d.word)
                    report_mismatch($sformatf("digest_word %h, expected %h",
                                              out_ch.digest_word, d.word));
                if (out_ch.word_index !== d.index)
                    report_mismatch($sformatf("word_index %0d, expected %0d",
                                              out_ch.word_index, d.index));
                if (out_ch.last_word !== d.last)
                    report_mismatch($sformatf("last_word %b, expected %b",
                                              out_ch.last_word, d.last));
                if (out_ch.length_error !== d.err)
                    report_mismatch($sformatf("length_error %b, expected %b",
                                              out_ch.length_error, d.err));
            end
        end
    end

    // Edge cases: empty message, "abc", extreme byte values, filler items
    task automatic test_directed();
        send_item(1'b0, 8'hff, 1'b1, 1'b0);
        send_item(1'b0, 8'h00, 1'b0, 1'b0);
        send_item(1'b1, 8'h61, 1'b0, 1'b0);
        send_item(1'b1, 8'h62, 1'b0, 1'b0);
        send_item(1'b1, 8'h63, 1'b1, 1'b0);
        send_item(1'b1, 8'hff, 1'b1, 1'b1);
        send_item(1'b1, 8'h00, 1'b0, 1'b1);
        send_item(1'b0, 8'hff, 1'b0, 1'b1);
        send_item(1'b0, 8'h5a, 1'b1, 1'b1);
    endtask

    // Two-block padding and a full block closed by its last byte
    task automatic test_block_boundaries();
        send_message(56, 1'b1, 1'b1);
        send_message(64, 1'b0, 1'b0);
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        hold_seq++;
        send_message(3, 1'b0, 1'b0);
        send_message(8, 1'b0, 1'b0);
        send_message(2, 1'b1, 1'b0);
    endtask

    // Sender pauses until every digest word is back
    task automatic test_drain_pause();
        send_message(5, 1'b0, 1'b1);
        wait_drained();
        send_message(1, 1'b1, 1'b1);
    endtask

    // Random short messages
    task automatic test_random_messages();
        int start;
        int len;
        start = items_sent;
        while (items_sent - start < 12)
        begin
            len = $urandom_range(0, 6);
            send_message(len, $urandom_range(0, 3) == 0, 1'b1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.has_byte = 1'b0;
        in_ch.data_byte = 8'h00;
        in_ch.end_of_message = 1'b0;
        out_ch.ready = 1'b0;
        restart_hash();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_block_boundaries();
        test_backpressure();
        test_drain_pause();
        test_random_messages();

        wait_drained();
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("PASS sha256_stream_hasher");
        else
            $display("FAIL sha256_stream_hasher");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("FAIL sha256_stream_hasher");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/sha_pkg.sv
design/sha_if.sv
design/sha_cmd_fifo.sv
design/sha_front.sv
design/sha_core.sv
design/sha256_stream_hasher.sv
test/tb_sha256_stream_hasher.sv
